// ----- src/hbt_pkg.sv -----
// Shared constants and types for the histogram bimodality test.
// No dependencies.
package hbt_pkg;
    localparam int MAX_BINS   = 256;
    localparam int MAX_PIXELS = 1024;
    localparam int BIN_AW     = 8;    // bin address width
    localparam int CNT_W      = 11;   // per-bin and total count width
    localparam int NB_W       = 9;
    localparam int CRIT_W     = 10;
    localparam int PIX_W      = 9;
    localparam int SUM_W      = 20;   // sum of count * value
    localparam int SQ_W       = 28;   // sum of count * value^2
    localparam int D_W        = 31;   // signed deviation numerator magnitude
    localparam int PROD_W     = 128;
    localparam logic [0:0] REG_NUM_BINS = 1'b0;
    localparam logic [0:0] REG_CRIT     = 1'b1;

    // Result of one window.
    typedef struct packed {
        logic            two_bodies;
        logic [PIX_W-1:0] best_threshold;
        logic            bad_pixel_seen;
    } result_t;
endpackage

// ----- src/histogram_bimodality_test.sv -----
// Histogram bimodality test: Otsu threshold sweep over a pixel histogram.
// Sequence: a plain pixel reads its bin and writes the incremented count; the last
//   pixel of a window also runs the histogram sums, then a threshold sweep through
//   the shared 128x32 multiplier with chained products, then the ratio test and a
//   clear of bin memory.
// Input: a new pixel is taken only after the last one is written; a window end stalls it.
// Reset: asynchronous, active low; clears control, then sweeps bin memory with
//   the input stalled.
module histogram_bimodality_test
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [hbt_pkg::CRIT_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hbt_pkg::PIX_W-1:0]     pixel,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          two_bodies,
    output logic [hbt_pkg::PIX_W-1:0]     best_threshold,
    output logic                          bad_pixel_seen
);
    localparam int AW = hbt_pkg::BIN_AW;
    localparam int PW = hbt_pkg::PROD_W;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_INC   = 5'd2;
    localparam logic [4:0] S_SRD   = 5'd3;
    localparam logic [4:0] S_SACC  = 5'd4;
    localparam logic [4:0] S_TRD   = 5'd5;
    localparam logic [4:0] S_TACC  = 5'd6;
    localparam logic [4:0] S_M1    = 5'd7;
    localparam logic [4:0] S_M2    = 5'd8;
    localparam logic [4:0] S_M3    = 5'd9;
    localparam logic [4:0] S_M4    = 5'd10;
    localparam logic [4:0] S_CMP   = 5'd11;
    localparam logic [4:0] S_F1    = 5'd12;
    localparam logic [4:0] S_F2    = 5'd13;
    localparam logic [4:0] S_F3    = 5'd14;
    localparam logic [4:0] S_F4    = 5'd15;
    localparam logic [4:0] S_F5    = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;
    localparam logic [4:0] S_SQ1   = 5'd18;
    localparam logic [4:0] S_SQ2   = 5'd19;

    // Bin memory
    logic [hbt_pkg::CNT_W-1:0] mem [0:hbt_pkg::MAX_BINS-1];
    logic [hbt_pkg::CNT_W-1:0] rd_reg;
    logic [AW-1:0]             raddr, waddr;
    logic                      we;
    logic [hbt_pkg::CNT_W-1:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    logic [4:0]  state_reg, state_next;
    logic [hbt_pkg::NB_W-1:0]   nb_cfg_reg;
    logic [hbt_pkg::CRIT_W-1:0] crit_reg;
    logic [hbt_pkg::CNT_W-1:0]  total_reg, total_next;
    logic                       bad_reg, bad_next;
    logic [8:0]                 idx_reg, idx_next;   // bin value / threshold
    logic [2:0]                 sub_reg, sub_next;
    logic [AW-1:0]              pa_reg, pa_next;
    logic                       last_reg, last_next;
    logic                       pok_reg, pok_next;
    logic [hbt_pkg::CNT_W-1:0]  nall_reg, nall_next, n1_reg, n1_next;
    logic [hbt_pkg::SUM_W-1:0]  sall_reg, sall_next, s1_reg, s1_next;
    logic [hbt_pkg::SQ_W-1:0]   qall_reg, qall_next;
    logic [hbt_pkg::SUM_W+hbt_pkg::CNT_W-1:0] d_reg, d_next, bd_reg, bd_next;
    logic [hbt_pkg::CNT_W-1:0]  bn1_reg, bn1_next, bn2_reg, bn2_next;
    logic [8:0]                 bt_reg, bt_next;
    logic [PW-1:0]              x_reg, x_next, y_reg, y_next;
    logic                       pass_reg, pass_next;
    logic                       ovalid_reg, ovalid_next;
    logic [hbt_pkg::SUM_W+hbt_pkg::CNT_W-1:0] t1_reg, t1_next;

    // multiplier
    logic          m_start, m_done;
    logic [PW-1:0] m_a, m_p;
    logic [31:0]   m_b;
    hbt_mul u_mul (.clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
                   .done(m_done), .p(m_p));

    logic [8:0] nb;
    logic [hbt_pkg::CNT_W-1:0] n2;
    logic [hbt_pkg::SUM_W-1:0] s2;
    logic [hbt_pkg::CNT_W+1:0] n4, n3;

    assign nb = (nb_cfg_reg > 9'd256) ? 9'd256 : nb_cfg_reg;
    assign n2 = nall_reg - n1_reg;
    assign s2 = sall_reg - s1_reg;
    assign n4 = {bn1_reg, 2'b00};
    assign n3 = {2'b00, nall_reg} + {1'b0, nall_reg, 1'b0};

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_cfg_reg <= 9'd256;
            crit_reg   <= 10'd700;
        end
        else if (cfg_we)
        begin
            if (cfg_index == hbt_pkg::REG_NUM_BINS)
                nb_cfg_reg <= cfg_data[8:0];
            else
                crit_reg <= cfg_data;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;  bad_next = bad_reg;
        idx_next = idx_reg;      sub_next = sub_reg;
        pa_next = pa_reg;        last_next = last_reg;  pok_next = pok_reg;
        nall_next = nall_reg;    sall_next = sall_reg;  qall_next = qall_reg;
        n1_next = n1_reg;        s1_next = s1_reg;
        d_next = d_reg;          bd_next = bd_reg;
        bn1_next = bn1_reg;      bn2_next = bn2_reg;    bt_next = bt_reg;
        x_next = x_reg;          y_next = y_reg;        t1_next = t1_reg;
        pass_next = pass_reg;    ovalid_next = ovalid_reg;
        raddr = pa_reg;          waddr = pa_reg;
        we = 1'b0;               wdata = rd_reg + 11'd1;
        m_start = 1'b0;          m_a = '0;  m_b = '0;
        case (state_reg)
            S_CLR:
            begin
                we = 1'b1; wdata = '0; waddr = idx_reg[AW-1:0];
                idx_next = idx_reg + 9'd1;
                if (idx_reg == 9'd255)
                begin
                    state_next = S_IDLE;
                    total_next = '0;
                    bad_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pa_next  = pixel[AW-1:0] - 8'd1;
                    raddr    = pixel[AW-1:0] - 8'd1;
                    last_next = last;
                    pok_next = (pixel >= 9'd1) && (pixel <= nb) &&
                               (total_reg < 11'(hbt_pkg::MAX_PIXELS));
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                if (pok_reg)
                begin
                    we = 1'b1;
                    total_next = total_reg + 11'd1;
                end
                else
                    bad_next = 1'b1;
                if (last_reg)
                begin
                    idx_next = 9'd1; nall_next = '0; sall_next = '0; qall_next = '0;
                    state_next = S_SRD;
                end
                else
                    state_next = S_IDLE;
            end
            // overall sums: count, sum, sum of squares
            S_SRD:
            begin
                raddr = idx_reg[AW-1:0] - 8'd1;
                state_next = S_SACC;
            end
            S_SACC:
            begin
                nall_next = nall_reg + rd_reg;
                t1_next = 31'(rd_reg * idx_reg);
                sall_next = sall_reg + 20'(rd_reg * idx_reg);
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                qall_next = qall_reg + 28'(t1_reg[19:0] * idx_reg);
                if (idx_reg >= nb)
                begin
                    idx_next = 9'd2; n1_next = '0; s1_next = '0; bt_next = '0;
                    state_next = S_TRD;
                end
                else
                begin
                    idx_next = idx_reg + 9'd1;
                    state_next = S_SRD;
                end
            end
            // threshold sweep
            S_TRD:
            begin
                raddr = idx_reg[AW-1:0] - 8'd2;
                if (idx_reg + 9'd1 > nb)
                    state_next = S_F1;
                else
                    state_next = S_TACC;
            end
            S_TACC:
            begin
                n1_next = n1_reg + rd_reg;
                s1_next = s1_reg + 20'(rd_reg * (idx_reg - 9'd1));
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                // d = s2*n1 - s1*n2, nonnegative by ordering of means
                d_next = 31'(s2 * n1_reg) - 31'(s1_reg * n2);
                if (n1_reg == '0 || n2 == '0)
                begin
                    idx_next = idx_reg + 9'd1;
                    state_next = S_TRD;
                end
                else if (bt_reg == '0)
                begin
                    bt_next = idx_reg; bd_next = 31'(s2 * n1_reg) - 31'(s1_reg * n2);
                    bn1_next = n1_reg; bn2_next = n2;
                    idx_next = idx_reg + 9'd1;
                    state_next = S_TRD;
                end
                else
                begin
                    m_start = 1'b1;
                    m_a = PW'(31'(s2 * n1_reg) - 31'(s1_reg * n2));
                    m_b = 32'(31'(s2 * n1_reg) - 31'(s1_reg * n2));
                    state_next = S_M1;
                end
            end
            S_M1: if (m_done)
            begin
                m_start = 1'b1; m_a = m_p; m_b = 32'(bn1_reg * bn2_reg);
                state_next = S_M2;
            end
            S_M2: if (m_done)
            begin
                x_next = m_p;
                m_start = 1'b1; m_a = PW'(bd_reg); m_b = 32'(bd_reg);
                state_next = S_M3;
            end
            S_M3: if (m_done)
            begin
                m_start = 1'b1; m_a = m_p; m_b = 32'(n1_reg * n2);
                state_next = S_M4;
            end
            S_M4: if (m_done)
            begin
                y_next = m_p;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (x_reg > y_reg)
                begin
                    bt_next = idx_reg; bd_next = d_reg;
                    bn1_next = n1_reg; bn2_next = n2;
                end
                idx_next = idx_reg + 9'd1;
                state_next = S_TRD;
            end
            // final ratio test
            S_F1:
            begin
                pass_next = 1'b0;
                if (bt_reg == '0)
                    state_next = S_OUT;
                else
                begin
                    m_start = 1'b1; m_a = PW'(nall_reg); m_b = 32'(qall_reg);
                    state_next = S_F2;
                end
            end
            S_F2: if (m_done)
            begin
                // spread = n*q - s*s, held in x
                x_next = m_p - PW'(sall_reg * sall_reg);
                m_start = 1'b1; m_a = PW'(bd_reg); m_b = 32'(bd_reg);
                state_next = S_F3;
            end
            S_F3: if (m_done)
            begin
                m_start = 1'b1; m_a = m_p; m_b = 32'd1000;
                state_next = S_F4;
            end
            S_F4: if (m_done)
            begin
                y_next = m_p;
                m_start = 1'b1; m_a = x_reg; m_b = 32'(bn1_reg * bn2_reg);
                state_next = S_F5;
            end
            S_F5:
            begin
                if (sub_reg == 3'd0)
                begin
                    if (m_done)
                    begin
                        m_start = 1'b1; m_a = m_p; m_b = 32'(crit_reg);
                        sub_next = 3'd1;
                    end
                end
                else if (m_done)
                begin
                    sub_next = 3'd0;
                    pass_next = (x_reg != '0) && (y_reg >= m_p) &&
                                (n4 >= {2'b00, nall_reg}) && (n4 <= n3);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    idx_next = '0;
                    state_next = S_CLR;
                end
            end
            default: state_next = S_CLR;
        endcase
        if (ovalid_reg && !out_stall && state_reg != S_OUT)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg <= '0;
            sub_reg <= '0;
            ovalid_reg <= 1'b0;
            total_reg <= '0;
            bad_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            sub_reg <= sub_next;
            ovalid_reg <= ovalid_next;
            total_reg <= total_next;
            bad_reg <= bad_next;
        end
    end

    hbt_pkg::result_t res_reg, res_next;
    always_comb
    begin
        res_next = res_reg;
        if (state_reg == S_OUT && (!ovalid_reg || !out_stall))
        begin
            res_next.two_bodies     = pass_reg;
            res_next.best_threshold = bt_reg;
            res_next.bad_pixel_seen = bad_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= pa_next;  last_reg <= last_next;  pok_reg <= pok_next;
        nall_reg <= nall_next; sall_reg <= sall_next; qall_reg <= qall_next;
        n1_reg <= n1_next;  s1_reg <= s1_next;  d_reg <= d_next;
        bd_reg <= bd_next;  bn1_reg <= bn1_next; bn2_reg <= bn2_next;
        bt_reg <= bt_next;  x_reg <= x_next;  y_reg <= y_next;  t1_reg <= t1_next;
        pass_reg <= pass_next;
        res_reg <= res_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = ovalid_reg;
    assign two_bodies     = res_reg.two_bodies;
    assign best_threshold = res_reg.best_threshold;
    assign bad_pixel_seen = res_reg.bad_pixel_seen;

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= 11'(hbt_pkg::MAX_PIXELS))
        else $error("pixel total above capacity");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(best_threshold))
        else $error("result changed while stalled");
    a_pass_thr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && two_bodies |-> best_threshold != '0)
        else $error("pass without threshold");
    a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> in_stall)
        else $error("input taken during clear");
endmodule

// ----- src/hbt_mul.sv -----
// Shared multiplier: 128-bit by 32-bit product, one 32x32 partial per cycle.
// Depends on hbt_pkg.
module hbt_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hbt_pkg::PROD_W-1:0]    a,
    input  logic [31:0]                   b,
    output logic                          done,
    output logic [hbt_pkg::PROD_W-1:0]    p
);
    logic [hbt_pkg::PROD_W-1:0] a_reg, a_next;
    logic [hbt_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [31:0]                b_reg, b_next;
    logic [2:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [63:0]                part;

    // one 32x32 partial product per cycle
    assign part = {32'd0, a_reg[31:0]} * {32'd0, b_reg};

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + ({64'd0, part} << (cnt_reg[1:0] * 32));
            a_next   = a_reg >> 32;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd3)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = busy_reg && (cnt_reg == 3'd3);
    assign p    = acc_reg + ({64'd0, part} << 96);

    // a product chained at done keeps the unit busy
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && !start |=> !busy_reg)
        else $error("multiplier still busy after done");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !done)
        else $error("done while idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == 3'd0)
        else $error("start did not arm multiplier");
endmodule

// ----- tb/sv/histogram_bimodality_test_tb.sv -----
`timescale 1ns / 1ps
// Testbench for histogram_bimodality_test: drives pixel windows, predicts each
// window's verdict with an Otsu sweep in exact integer math, compares results.
// Depends on hbt_pkg and the histogram_bimodality_test RTL.
module histogram_bimodality_test_tb;

    localparam int LIMIT_CYCLES = 3000000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [0:0]                 cfg_index = hbt_pkg::REG_NUM_BINS;
    logic [hbt_pkg::CRIT_W-1:0] cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [hbt_pkg::PIX_W-1:0]  pixel = '0;
    logic                       last = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       two_bodies;
    logic [hbt_pkg::PIX_W-1:0]  best_threshold;
    logic                       bad_pixel_seen;

    histogram_bimodality_test u_dut (.*);

    always #6 clk = ~clk;

    // Predictor state
    int unsigned hist[hbt_pkg::MAX_BINS];
    int unsigned win_count;
    bit          win_bad;
    int unsigned bins_cfg = 256;
    int unsigned crit_cfg = 700;

    hbt_pkg::result_t verdict_q[$];
    int          mismatches = 0;
    int          windows_done = 0;
    int          requests = 0;
    longint      cycles = 0;
    bit          stim_done = 0;
    int          out_wait = 0;

    // Directed table: pixel, last, expected-known flag, expected verdict
    typedef struct {
        int unsigned      pix;
        bit               lst;
        bit               known;
        hbt_pkg::result_t exp_r;
    } dir_row_t;

    // Predict one accepted pixel; push a verdict when it closes the window.
    task automatic predict_pixel(input int unsigned pix, input bit lst);
        int unsigned nb, bt, t, v;
        logic [127:0] n_all, s_all, q_all, n1, s1, n2, s2, d, bd, bn1, bn2;
        logic [127:0] lhs, rhs, spread, c;
        bit pass;
        hbt_pkg::result_t r;
        begin
            nb = (bins_cfg > hbt_pkg::MAX_BINS) ? hbt_pkg::MAX_BINS : bins_cfg;
            if (pix >= 1 && pix <= nb && win_count < hbt_pkg::MAX_PIXELS)
            begin
                hist[pix-1]++;
                win_count++;
            end
            else
                win_bad = 1;
            if (lst)
            begin
                n_all = 0; s_all = 0; q_all = 0; n1 = 0; s1 = 0;
                bd = 0; bn1 = 0; bn2 = 0; bt = 0; pass = 0;
                for (v = 1; v <= nb; v++)
                begin
                    c = hist[v-1];
                    n_all += c; s_all += c * v; q_all += c * v * v;
                end
                for (t = 2; t + 1 <= nb; t++)
                begin
                    c = hist[t-2];
                    n1 += c; s1 += c * (t - 1);
                    n2 = n_all - n1; s2 = s_all - s1;
                    if (n1 == 0 || n2 == 0) continue;
                    d = s2 * n1 - s1 * n2;
                    if (bt == 0 || d * d * (bn1 * bn2) > bd * bd * (n1 * n2))
                    begin
                        bt = t; bd = d; bn1 = n1; bn2 = n2;
                    end
                end
                if (bt != 0)
                begin
                    spread = n_all * q_all - s_all * s_all;
                    lhs = bd * bd * 1000;
                    rhs = spread * (bn1 * bn2) * crit_cfg;
                    pass = spread != 0 && lhs >= rhs
                           && 4 * bn1 >= n_all && 4 * bn1 <= 3 * n_all;
                end
                r.two_bodies = pass;
                r.best_threshold = bt[hbt_pkg::PIX_W-1:0];
                r.bad_pixel_seen = win_bad;
                verdict_q.push_back(r);
                foreach (hist[i]) hist[i] = 0;
                win_count = 0;
                win_bad = 0;
            end
        end
    endtask

    // Send one request with a random lead-in gap; valid stays up until the
    // next request or an explicit drop, so back-to-back requests have no gap.
    task automatic send_pixel(input int unsigned pix, input bit lst);
        int gap;
        begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            pixel <= pix[hbt_pkg::PIX_W-1:0];
            last <= lst;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            predict_pixel(pix, lst);
            requests++;
            @(negedge clk);
        end
    endtask

    // Register write while idle: drain results, let the clear finish too.
    task automatic write_reg(input logic [0:0] idx, input int unsigned val);
        begin
            in_valid <= 1'b0;
            while (verdict_q.size() != 0) @(negedge clk);
            repeat (1200) @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val[hbt_pkg::CRIT_W-1:0];
            @(negedge clk);
            cfg_we <= 1'b0;
            if (idx == hbt_pkg::REG_NUM_BINS) bins_cfg = val & 9'h1FF;
            else crit_cfg = val & 10'h3FF;
        end
    endtask

    // One random window: mostly two clusters, sometimes noise or bad pixels.
    task automatic random_window(input int unsigned len);
        int unsigned nb, a, b, p, k;
        begin
            nb = (bins_cfg > hbt_pkg::MAX_BINS) ? hbt_pkg::MAX_BINS : bins_cfg;
            a = $urandom_range(1, nb);
            b = $urandom_range(1, nb);
            for (k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 9))
                    0: p = $urandom_range(0, 511);
                    1, 2: p = $urandom_range(1, nb);
                    3: p = 0;
                    default: p = ($urandom_range(0, 1) ? a : b);
                endcase
                if (p >= 1 && p <= nb && $urandom_range(0, 9) < 5)
                    p = (p + $urandom_range(0, 2) + nb - 1 - 1) % nb + 1;
                send_pixel(p, k == len - 1);
            end
        end
    endtask

    // Output stall: each result waits a drawn number of cycles
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (out_valid && out_wait != 0)
        begin
            out_stall <= 1'b1;
            out_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    // Result checking
    always @(posedge clk)
    begin
        hbt_pkg::result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            out_wait = $urandom_range(0, 11);
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0b %0d %0b",
                    two_bodies, best_threshold, bad_pixel_seen);
            end
            else
            begin
                e = verdict_q.pop_front();
                windows_done++;
                if (e.two_bodies !== two_bodies || e.best_threshold !== best_threshold
                    || e.bad_pixel_seen !== bad_pixel_seen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0b/%0d/%0b got %0b/%0d/%0b",
                            e.two_bodies, e.best_threshold, e.bad_pixel_seen,
                            two_bodies, best_threshold, bad_pixel_seen);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows[$];
        dir_row_t rw;
        int k, n;
        hbt_pkg::result_t zr;
        foreach (hist[i]) hist[i] = 0;
        win_count = 0;
        win_bad = 0;
        out_wait = $urandom_range(0, 11);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: lone bad last, extremes, empty classes, valid split
        zr = '0;
        rw.known = 1; rw.pix = 0; rw.lst = 1;
        rw.exp_r = zr; rw.exp_r.bad_pixel_seen = 1; rows.push_back(rw);
        rw.pix = 256; rw.lst = 1;
        rw.exp_r = zr; rows.push_back(rw);
        rw.pix = 257; rw.lst = 0; rw.known = 0; rows.push_back(rw);
        rw.pix = 1; rows.push_back(rw);
        rw.pix = 256; rw.lst = 1; rows.push_back(rw);
        for (k = 0; k < 4; k++) begin rw.pix = 10; rw.lst = 0; rows.push_back(rw); end
        for (k = 0; k < 4; k++) begin rw.pix = 200; rw.lst = (k == 3); rows.push_back(rw); end
        rw.pix = 511; rw.lst = 0; rows.push_back(rw);
        rw.pix = 255; rw.lst = 1; rows.push_back(rw);
        foreach (rows[i])
        begin
            send_pixel(rows[i].pix, rows[i].lst);
            if (rows[i].known && rows[i].lst)
                verdict_q[verdict_q.size()-1] = rows[i].exp_r;
        end

        // Window overflow: more pixels than capacity in one window
        for (k = 0; k < hbt_pkg::MAX_PIXELS + 3; k++)
            send_pixel((k % 2) ? 3 : 250, k == hbt_pkg::MAX_PIXELS + 2);

        // Configuration sweeps through extremes and random settings
        n = 0;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: begin write_reg(hbt_pkg::REG_NUM_BINS, 3); write_reg(hbt_pkg::REG_CRIT, 0); end
                1: write_reg(hbt_pkg::REG_CRIT, 1000);
                2: write_reg(hbt_pkg::REG_NUM_BINS, 2);
                3: begin
                    write_reg(hbt_pkg::REG_NUM_BINS, 511);
                    write_reg(hbt_pkg::REG_CRIT, 1023);
                end
                4: begin write_reg(hbt_pkg::REG_NUM_BINS, 8); write_reg(hbt_pkg::REG_CRIT, 500); end
                9: begin
                    write_reg(hbt_pkg::REG_NUM_BINS, 256);
                    write_reg(hbt_pkg::REG_CRIT, 700);
                end
                default: begin
                    write_reg(hbt_pkg::REG_NUM_BINS, $urandom_range(3, 64));
                    write_reg(hbt_pkg::REG_CRIT, $urandom_range(0, 1000));
                end
            endcase
            while (n < (ph + 1) * 25)
            begin
                k = $urandom_range(1, 16);
                random_window(k);
                n += k;
            end
            // mid-window bin count change, window ends under the new count
            if (ph == 5)
            begin
                send_pixel(40, 0);
                in_valid <= 1'b0;
                repeat (2) @(negedge clk);
                cfg_we <= 1'b1; cfg_index <= hbt_pkg::REG_NUM_BINS; cfg_data <= 10'd20;
                @(negedge clk);
                cfg_we <= 1'b0;
                bins_cfg = 20;
                send_pixel(5, 1);
            end
        end

        stim_done = 1;
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge clk);
        repeat (1500) @(negedge clk);
        $display("Sent %0d pixel requests, checked %0d window verdicts",
            requests, windows_done);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
